[design/psh_pkg.sv]
// Package for the parity split heap sorter.
// Holds shared constants, controller states, datapath commands and status.
// No dependencies.
`default_nettype none

package psh_pkg;

    localparam int CAPACITY_DEF    = 32;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FIELD_WIDTH     = 16;

    localparam logic GRP_ODD  = 1'b0;
    localparam logic GRP_EVEN = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GRP_INIT,
        ST_BLD_CHK,
        ST_BLD_RD,
        ST_BLD_X,
        ST_SIFT_L,
        ST_SIFT_R,
        ST_SIFT_CMP,
        ST_SIFT_END,
        ST_SORT_INIT,
        ST_SORT_CHK,
        ST_SW_RD0,
        ST_SW_RD1,
        ST_SW_WR,
        ST_EM_INIT,
        ST_EM_OUT,
        ST_GRP_END
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_GRP_INIT,
        OP_BLD_RD,
        OP_X_RD,
        OP_READ_L,
        OP_READ_R,
        OP_MOVE,
        OP_SIFT_END,
        OP_SORT_INIT,
        OP_SW_RD0,
        OP_SW_RD1,
        OP_SW_WR,
        OP_EM_INIT,
        OP_EM_OUT,
        OP_GRP_NEXT,
        OP_CLEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic k_zero;
        logic k_le1;
        logic n_zero;
        logic leaf;
        logic stop;
        logic last_emit;
        logic grp_even;
    } t_dp_stat;

endpackage

`default_nettype wire

[design/psh_ctrl.sv]
// Controller state machine of the parity split heap sorter.
// Sequences load, heap build, sort and emit per group; uses psh_pkg.
`default_nettype none

module psh_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_final_item,
    input  wire psh_pkg::t_dp_stat i_stat,
    output psh_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);

    psh_pkg::t_state r_state, n_state;
    logic            r_sorting, n_sorting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= psh_pkg::ST_IDLE;
            r_sorting <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sorting <= n_sorting;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_sorting = r_sorting;
        unique case (r_state)
            psh_pkg::ST_IDLE: begin
                if (i_start && i_final_item) n_state = psh_pkg::ST_GRP_INIT;
            end
            psh_pkg::ST_GRP_INIT: begin
                n_sorting = 1'b0;
                n_state   = psh_pkg::ST_BLD_CHK;
            end
            psh_pkg::ST_BLD_CHK: begin
                n_state = i_stat.k_zero ? psh_pkg::ST_SORT_INIT : psh_pkg::ST_BLD_RD;
            end
            psh_pkg::ST_BLD_RD:   n_state = psh_pkg::ST_BLD_X;
            psh_pkg::ST_BLD_X:    n_state = psh_pkg::ST_SIFT_L;
            psh_pkg::ST_SIFT_L: begin
                n_state = i_stat.leaf ? psh_pkg::ST_SIFT_END : psh_pkg::ST_SIFT_R;
            end
            psh_pkg::ST_SIFT_R:   n_state = psh_pkg::ST_SIFT_CMP;
            psh_pkg::ST_SIFT_CMP: begin
                n_state = i_stat.stop ? psh_pkg::ST_SIFT_END : psh_pkg::ST_SIFT_L;
            end
            psh_pkg::ST_SIFT_END: begin
                n_state = r_sorting ? psh_pkg::ST_SORT_CHK : psh_pkg::ST_BLD_CHK;
            end
            psh_pkg::ST_SORT_INIT: begin
                n_sorting = 1'b1;
                n_state   = psh_pkg::ST_SORT_CHK;
            end
            psh_pkg::ST_SORT_CHK: begin
                n_state = i_stat.k_le1 ? psh_pkg::ST_EM_INIT : psh_pkg::ST_SW_RD0;
            end
            psh_pkg::ST_SW_RD0:   n_state = psh_pkg::ST_SW_RD1;
            psh_pkg::ST_SW_RD1:   n_state = psh_pkg::ST_SW_WR;
            psh_pkg::ST_SW_WR:    n_state = psh_pkg::ST_SIFT_L;
            psh_pkg::ST_EM_INIT: begin
                n_state = i_stat.n_zero ? psh_pkg::ST_GRP_END : psh_pkg::ST_EM_OUT;
            end
            psh_pkg::ST_EM_OUT: begin
                if (i_stat.last_emit) n_state = psh_pkg::ST_GRP_END;
            end
            psh_pkg::ST_GRP_END: begin
                n_state = i_stat.grp_even ? psh_pkg::ST_IDLE : psh_pkg::ST_GRP_INIT;
            end
            default: n_state = psh_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = psh_pkg::OP_NOP;
        o_busy   = 1'b1;
        unique case (r_state)
            psh_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) o_cmd.op = psh_pkg::OP_LOAD;
            end
            psh_pkg::ST_GRP_INIT:  o_cmd.op = psh_pkg::OP_GRP_INIT;
            psh_pkg::ST_BLD_CHK:   o_cmd.op = psh_pkg::OP_NOP;
            psh_pkg::ST_BLD_RD:    o_cmd.op = psh_pkg::OP_BLD_RD;
            psh_pkg::ST_BLD_X:     o_cmd.op = psh_pkg::OP_X_RD;
            psh_pkg::ST_SIFT_L: begin
                if (!i_stat.leaf) o_cmd.op = psh_pkg::OP_READ_L;
            end
            psh_pkg::ST_SIFT_R:    o_cmd.op = psh_pkg::OP_READ_R;
            psh_pkg::ST_SIFT_CMP: begin
                if (!i_stat.stop) o_cmd.op = psh_pkg::OP_MOVE;
            end
            psh_pkg::ST_SIFT_END:  o_cmd.op = psh_pkg::OP_SIFT_END;
            psh_pkg::ST_SORT_INIT: o_cmd.op = psh_pkg::OP_SORT_INIT;
            psh_pkg::ST_SORT_CHK:  o_cmd.op = psh_pkg::OP_NOP;
            psh_pkg::ST_SW_RD0:    o_cmd.op = psh_pkg::OP_SW_RD0;
            psh_pkg::ST_SW_RD1:    o_cmd.op = psh_pkg::OP_SW_RD1;
            psh_pkg::ST_SW_WR:     o_cmd.op = psh_pkg::OP_SW_WR;
            psh_pkg::ST_EM_INIT: begin
                if (!i_stat.n_zero) o_cmd.op = psh_pkg::OP_EM_INIT;
            end
            psh_pkg::ST_EM_OUT:    o_cmd.op = psh_pkg::OP_EM_OUT;
            psh_pkg::ST_GRP_END: begin
                o_cmd.op = i_stat.grp_even ? psh_pkg::OP_CLEAR : psh_pkg::OP_GRP_NEXT;
            end
            default:               o_cmd.op = psh_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

[design/psh_dp.sv]
// Datapath of the parity split heap sorter: group store memory, counts,
// sift-down registers and result registers. Driven by psh_ctrl; uses psh_pkg.
`default_nettype none

module psh_dp #(
    parameter int CAPACITY    = psh_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = psh_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire psh_pkg::t_dp_cmd              i_cmd,
    input  wire logic [psh_pkg::FIELD_WIDTH-1:0] i_value,
    output psh_pkg::t_dp_stat                  o_stat,
    output logic                               o_valid,
    output logic [psh_pkg::FIELD_WIDTH-1:0]    o_sorted_value,
    output logic                               o_group,
    output logic                               o_group_end,
    output logic                               o_batch_end,
    output logic                               o_overflowed
);

    localparam int FW    = psh_pkg::FIELD_WIDTH;
    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int LW    = AW + 2;
    localparam int KW    = (VALUE_WIDTH < FW) ? VALUE_WIDTH : FW;
    localparam int DEPTH = 2 * (2 ** AW);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    logic [CW-1:0]          r_cnt_odd, r_cnt_even;
    logic                   r_ovf, r_grp, r_out_valid;
    logic [CW-1:0]          r_n, r_hn, r_k;
    logic [AW-1:0]          r_at;
    logic [VALUE_WIDTH-1:0] r_x, r_lv, r_t, r_rdata;
    logic [FW-1:0]          r_out_value;
    logic                   r_out_group, r_out_gend, r_out_bend, r_out_ovf;

    logic                   w_in_grp, w_full;
    logic [CW-1:0]          w_in_cnt, w_cur_cnt, w_km1, w_kp1;
    logic [VALUE_WIDTH-1:0] w_in_val;
    logic [LW-1:0]          w_l, w_r;
    logic                   w_has_r, w_left_big, w_right_big;
    logic [VALUE_WIDTH-1:0] w_bv;
    logic [AW-1:0]          w_big;
    logic                   w_we, w_re;
    logic [AW:0]            w_waddr, w_raddr;
    logic [VALUE_WIDTH-1:0] w_wdata;

    assign w_in_val  = VALUE_WIDTH'(i_value[KW-1:0]);
    assign w_in_grp  = ~i_value[0];
    assign w_in_cnt  = w_in_grp ? r_cnt_even : r_cnt_odd;
    assign w_full    = (w_in_cnt == CW'(CAPACITY));
    assign w_cur_cnt = r_grp ? r_cnt_even : r_cnt_odd;
    assign w_km1     = r_k - 1'b1;
    assign w_kp1     = r_k + 1'b1;

    assign w_l     = {1'b0, r_at, 1'b0} | LW'(1);
    assign w_r     = w_l + LW'(1);
    assign w_has_r = (w_r < LW'(r_hn));

    always_comb begin
        w_left_big  = (r_lv > r_x);
        w_bv        = w_left_big ? r_lv : r_x;
        w_right_big = w_has_r && (r_rdata > w_bv);
        w_big       = r_at;
        if (w_left_big) w_big = w_l[AW-1:0];
        if (w_right_big) begin
            w_big = w_r[AW-1:0];
            w_bv  = r_rdata;
        end
    end

    assign o_stat.k_zero    = (r_k == '0);
    assign o_stat.k_le1     = (r_k <= CW'(1));
    assign o_stat.n_zero    = (r_n == '0);
    assign o_stat.leaf      = !(w_l < LW'(r_hn));
    assign o_stat.stop      = !(w_left_big || w_right_big);
    assign o_stat.last_emit = (w_kp1 == r_n);
    assign o_stat.grp_even  = r_grp;

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = {r_grp, r_at};
        w_raddr = {r_grp, r_at};
        w_wdata = r_x;
        unique case (i_cmd.op)
            psh_pkg::OP_LOAD: begin
                w_we    = !w_full;
                w_waddr = {w_in_grp, w_in_cnt[AW-1:0]};
                w_wdata = w_in_val;
            end
            psh_pkg::OP_BLD_RD: begin
                w_re    = 1'b1;
                w_raddr = {r_grp, w_km1[AW-1:0]};
            end
            psh_pkg::OP_READ_L: begin
                w_re    = 1'b1;
                w_raddr = {r_grp, w_l[AW-1:0]};
            end
            psh_pkg::OP_READ_R: begin
                w_re    = 1'b1;
                w_raddr = {r_grp, w_r[AW-1:0]};
            end
            psh_pkg::OP_MOVE: begin
                w_we    = 1'b1;
                w_wdata = w_bv;
            end
            psh_pkg::OP_SIFT_END: begin
                w_we    = 1'b1;
            end
            psh_pkg::OP_SW_RD0: begin
                w_re    = 1'b1;
                w_raddr = {r_grp, AW'(0)};
            end
            psh_pkg::OP_SW_RD1: begin
                w_re    = 1'b1;
                w_raddr = {r_grp, w_km1[AW-1:0]};
            end
            psh_pkg::OP_SW_WR: begin
                w_we    = 1'b1;
                w_waddr = {r_grp, w_km1[AW-1:0]};
                w_wdata = r_t;
            end
            psh_pkg::OP_EM_INIT: begin
                w_re    = 1'b1;
                w_raddr = {r_grp, AW'(0)};
            end
            psh_pkg::OP_EM_OUT: begin
                w_re    = 1'b1;
                w_raddr = {r_grp, w_kp1[AW-1:0]};
            end
            default: begin
                w_we = 1'b0;
                w_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        if (w_re) r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_odd   <= '0;
            r_cnt_even  <= '0;
            r_ovf       <= 1'b0;
            r_grp       <= psh_pkg::GRP_ODD;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.op == psh_pkg::OP_EM_OUT);
            unique case (i_cmd.op)
                psh_pkg::OP_LOAD: begin
                    if (w_full) begin
                        r_ovf <= 1'b1;
                    end else if (w_in_grp) begin
                        r_cnt_even <= CW'(r_cnt_even + 1'b1);
                    end else begin
                        r_cnt_odd <= CW'(r_cnt_odd + 1'b1);
                    end
                end
                psh_pkg::OP_GRP_NEXT: r_grp <= psh_pkg::GRP_EVEN;
                psh_pkg::OP_CLEAR: begin
                    r_grp      <= psh_pkg::GRP_ODD;
                    r_cnt_odd  <= '0;
                    r_cnt_even <= '0;
                    r_ovf      <= 1'b0;
                end
                default: r_grp <= r_grp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            psh_pkg::OP_GRP_INIT: begin
                r_n  <= w_cur_cnt;
                r_hn <= w_cur_cnt;
                r_k  <= w_cur_cnt >> 1;
            end
            psh_pkg::OP_BLD_RD:   r_at <= w_km1[AW-1:0];
            psh_pkg::OP_X_RD:     r_x  <= r_rdata;
            psh_pkg::OP_READ_R:   r_lv <= r_rdata;
            psh_pkg::OP_MOVE:     r_at <= w_big;
            psh_pkg::OP_SIFT_END: r_k  <= w_km1;
            psh_pkg::OP_SORT_INIT: r_k <= r_n;
            psh_pkg::OP_SW_RD1:   r_t  <= r_rdata;
            psh_pkg::OP_SW_WR: begin
                r_x  <= r_rdata;
                r_at <= '0;
                r_hn <= w_km1;
            end
            psh_pkg::OP_EM_INIT:  r_k  <= '0;
            psh_pkg::OP_EM_OUT: begin
                r_k         <= w_kp1;
                r_out_value <= FW'(r_rdata[KW-1:0]);
                r_out_group <= r_grp;
                r_out_gend  <= o_stat.last_emit;
                r_out_bend  <= o_stat.last_emit && (r_grp || (r_cnt_even == '0));
                r_out_ovf   <= r_ovf;
            end
            default: r_at <= r_at;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_group        = r_out_group;
    assign o_group_end    = r_out_gend;
    assign o_batch_end    = r_out_bend;
    assign o_overflowed   = r_out_ovf;

endmodule

`default_nettype wire

[design/parity_split_heap_sorter.sv]
// A value that is not final is stored in the cycle it is taken, one per cycle while idle.
// After the final value, each group is heap sorted in place through one read and one
// write port of the store memory, with n/2 + n - 1 sifts per group; a group then streams
// one result per cycle. Results cannot be stalled. Synchronous reset clears counts, the
// overflow flag and the controller; store contents are left as they are.
`default_nettype none

module parity_split_heap_sorter #(
    parameter int CAPACITY    = psh_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = psh_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [psh_pkg::FIELD_WIDTH-1:0] i_value,
    input  wire logic                            i_final_item,
    output logic                                 o_valid,
    output logic [psh_pkg::FIELD_WIDTH-1:0]      o_sorted_value,
    output logic                                 o_group,
    output logic                                 o_group_end,
    output logic                                 o_batch_end,
    output logic                                 o_overflowed
);

    psh_pkg::t_dp_cmd  w_cmd;
    psh_pkg::t_dp_stat w_stat;

    psh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_final_item (i_final_item),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_busy       (busy)
    );

    psh_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (i_value),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_group        (o_group),
        .o_group_end    (o_group_end),
        .o_batch_end    (o_batch_end),
        .o_overflowed   (o_overflowed)
    );

endmodule

`default_nettype wire

[design/psh_checker.sv]
// Port-level checker for the parity split heap sorter, bound to the top level.
// Depends on psh_pkg for the field width.
`default_nettype none

module psh_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            start,
    input wire logic                            busy,
    input wire logic                            i_final_item,
    input wire logic                            o_valid,
    input wire logic [psh_pkg::FIELD_WIDTH-1:0] o_sorted_value,
    input wire logic                            o_group_end,
    input wire logic                            o_batch_end
);

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without a batch in progress");

    a_final_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_final_item) |=> busy)
        else $error("final beat did not start sorting");

    a_batch_end_is_group_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_batch_end) |-> o_group_end)
        else $error("batch end without group end");

    a_group_ascends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_group_end) |=> (o_sorted_value >= $past(o_sorted_value)))
        else $error("results of a group out of order");

    a_group_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_group_end) |=> o_valid)
        else $error("gap inside a group's result stream");

endmodule

bind parity_split_heap_sorter psh_checker u_psh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_final_item   (i_final_item),
    .o_valid        (o_valid),
    .o_sorted_value (o_sorted_value),
    .o_group_end    (o_group_end),
    .o_batch_end    (o_batch_end)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for parity_split_heap_sorter: random batches in bursts, sorted results
// predicted per batch and compared field by field as they stream out.
// Depends on psh_pkg and the parity_split_heap_sorter RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_WIDTH = psh_pkg::FIELD_WIDTH;
    localparam int STORE_DEPTH = psh_pkg::CAPACITY_DEF;
    localparam int ITEM_TARGET = 500;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] sorted_value;
        logic                   group;
        logic                   group_end;
        logic                   batch_end;
        logic                   overflowed;
    } t_sort_result;

    class parity_sort_board;
        logic [FIELD_WIDTH-1:0] odd_vals[$];
        logic [FIELD_WIDTH-1:0] even_vals[$];
        bit                     dropped;
        t_sort_result           due_results[$];
        int                     errors;

        function void file_value(input logic [FIELD_WIDTH-1:0] v,
                                 input logic [FIELD_WIDTH-1:0] vals[$],
                                 output logic [FIELD_WIDTH-1:0] merged[$]);
            int idx;
            merged = vals;
            idx = 0;
            while (idx < merged.size() && merged[idx] <= v)
                idx++;
            merged.insert(idx, v);
        endfunction

        function void emit_group(input logic [FIELD_WIDTH-1:0] vals[$], input logic grp,
                                 input bit closes_batch);
            t_sort_result r;
            for (int k = 0; k < vals.size(); k++) begin
                r.sorted_value = vals[k];
                r.group        = grp;
                r.group_end    = (k == vals.size() - 1);
                r.batch_end    = r.group_end && closes_batch;
                r.overflowed   = dropped;
                due_results.push_back(r);
            end
        endfunction

        function void note_value(input logic [FIELD_WIDTH-1:0] v, input logic fin);
            logic [FIELD_WIDTH-1:0] merged[$];
            if (v[0]) begin
                if (odd_vals.size() < STORE_DEPTH) begin
                    file_value(v, odd_vals, merged);
                    odd_vals = merged;
                end else begin
                    dropped = 1'b1;
                end
            end else begin
                if (even_vals.size() < STORE_DEPTH) begin
                    file_value(v, even_vals, merged);
                    even_vals = merged;
                end else begin
                    dropped = 1'b1;
                end
            end
            if (!fin)
                return;
            emit_group(odd_vals, psh_pkg::GRP_ODD, even_vals.size() == 0);
            emit_group(even_vals, psh_pkg::GRP_EVEN, 1'b1);
            odd_vals.delete();
            even_vals.delete();
            dropped = 1'b0;
        endfunction

        function void check_result(input t_sort_result got);
            t_sort_result want;
            if (due_results.size() == 0) begin
                $error("result with nothing pending: value %0d group %0d",
                       got.sorted_value, got.group);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.sorted_value !== want.sorted_value) begin
                $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                       got.sorted_value);
                errors++;
            end
            if (got.group !== want.group) begin
                $error("group: expected %0d, got %0d", want.group, got.group);
                errors++;
            end
            if (got.group_end !== want.group_end) begin
                $error("group_end: expected %0d, got %0d", want.group_end, got.group_end);
                errors++;
            end
            if (got.batch_end !== want.batch_end) begin
                $error("batch_end: expected %0d, got %0d", want.batch_end, got.batch_end);
                errors++;
            end
            if (got.overflowed !== want.overflowed) begin
                $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [FIELD_WIDTH-1:0] i_value;
    logic                   i_final_item;
    logic                   o_valid;
    logic [FIELD_WIDTH-1:0] o_sorted_value;
    logic                   o_group;
    logic                   o_group_end;
    logic                   o_batch_end;
    logic                   o_overflowed;

    parity_split_heap_sorter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_final_item   (i_final_item),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_group        (o_group),
        .o_group_end    (o_group_end),
        .o_batch_end    (o_batch_end),
        .o_overflowed   (o_overflowed)
    );

    parity_sort_board board = new();
    int               burst_left;
    int               items_sent;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            board.note_value(i_value, i_final_item);
    end

    always @(posedge i_clk) begin
        t_sort_result got;
        if (i_rst_n && o_valid) begin
            got.sorted_value = o_sorted_value;
            got.group        = o_group;
            got.group_end    = o_group_end;
            got.batch_end    = o_batch_end;
            got.overflowed   = o_overflowed;
            board.check_result(got);
        end
    end

    task automatic idle_gap(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start        = 1'b0;
            i_value      = FIELD_WIDTH'($urandom);
            i_final_item = 1'($urandom);
        end
    endtask

    // hold the beat until the block takes it
    task automatic send_beat(input logic [FIELD_WIDTH-1:0] v, input logic fin);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        start        = 1'b1;
        i_value      = v;
        i_final_item = fin;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // parity mode: 0 random, 1 mostly odd, 2 mostly even, 3 all odd, 4 all even
    task automatic send_batch(input int len, input int mode);
        logic [FIELD_WIDTH-1:0] v;
        logic                   par;
        for (int k = 0; k < len; k++) begin
            v = ($urandom_range(0, 3) == 0) ? FIELD_WIDTH'($urandom_range(0, 15))
                                             : FIELD_WIDTH'($urandom);
            case (mode)
                1: par = ($urandom_range(0, 9) != 0);
                2: par = ($urandom_range(0, 9) == 0);
                3: par = 1'b1;
                4: par = 1'b0;
                default: par = 1'($urandom);
            endcase
            v[0] = par;
            send_beat(v, k == len - 1);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_value      = '0;
        i_final_item = 1'b0;
        burst_left   = 0;
        items_sent   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(16'hFFFF, 1'b1);
        send_beat(16'h0000, 1'b1);
        send_beat(16'h0001, 1'b0);
        send_beat(16'hFFFE, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h5555, 1'b0);
        send_beat(16'hAAAA, 1'b0);
        send_beat(16'hAAAA, 1'b1);
        send_beat(16'd5, 1'b0);
        send_beat(16'd3, 1'b0);
        send_beat(16'd3, 1'b0);
        send_beat(16'd9, 1'b0);
        send_beat(16'd1, 1'b1);
        send_beat(16'd8, 1'b0);
        send_beat(16'd2, 1'b0);
        send_beat(16'd2, 1'b0);
        send_beat(16'd0, 1'b1);

        send_batch($urandom_range(33, 40), 3);
        send_batch($urandom_range(33, 40), 4);
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0, 1, 2:    send_batch($urandom_range(11, 32), 0);
                3:          send_batch($urandom_range(33, 70), 1);
                4:          send_batch($urandom_range(33, 70), 2);
                5:          send_batch($urandom_range(60, 70), 0);
                default:    send_batch($urandom_range(1, 10), 0);
            endcase
        end

        @(negedge i_clk);
        start        = 1'b0;
        i_final_item = 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
